/* sv/fmms_pkg.sv */
`default_nettype none

package fmms_pkg;

   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 7;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int QUOT_SAT_BIT = 40;

   typedef enum logic [1:0] {
      KIND_LEARN_FIRST  = 2'd0,
      KIND_LEARN_UPDATE = 2'd1,
      KIND_SCALE        = 2'd2,
      KIND_UNUSED       = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_LOWER_BOUND = 1'b0,
      CSR_UPPER_BOUND = 1'b1
   } csr_index_type;

   localparam logic signed [VALUE_W-1:0] LOWER_BOUND_RESET = -32'sd65536;
   localparam logic signed [VALUE_W-1:0] UPPER_BOUND_RESET = 32'sd65536;

   // one slot of the divider pipeline with the result info riding along
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] idx;
      logic               flat;
      logic               use_direct;
      logic [VALUE_W-1:0] direct;
      logic               neg;
      logic [VALUE_W-1:0] den;
      logic [VALUE_W-1:0] rem;
      logic [PROD_W-1:0]  dq;
   } div_stage_type;

endpackage

`default_nettype wire

/* sv/fmms_store.sv */
`default_nettype none

module fmms_store #(
   parameter int DIMENSIONS = 128,
   parameter int AW = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [AW-1:0]                  rd_addr,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [fmms_pkg::VALUE_W-1:0]   wr_min,
   input  wire logic [fmms_pkg::VALUE_W-1:0]   wr_max,
   output logic      [fmms_pkg::VALUE_W-1:0]   rd_min,
   output logic      [fmms_pkg::VALUE_W-1:0]   rd_max
);
   import fmms_pkg::*;

   logic [VALUE_W-1:0] min_mem [DIMENSIONS];
   logic [VALUE_W-1:0] max_mem [DIMENSIONS];

   logic [VALUE_W-1:0] rmin_ff, rmax_ff, fmin_ff, fmax_ff;
   logic               fwd_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr_en) begin
            min_mem[wr_addr] <= wr_min;
            max_mem[wr_addr] <= wr_max;
         end
         rmin_ff <= min_mem[rd_addr];
         rmax_ff <= max_mem[rd_addr];
         fmin_ff <= wr_min;
         fmax_ff <= wr_max;
      end
   end

   // a write landing in the read cycle of the same entry wins over the stale read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (advance) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_min = fwd_ff ? fmin_ff : rmin_ff;
   assign rd_max = fwd_ff ? fmax_ff : rmax_ff;

endmodule

`default_nettype wire

/* sv/fmms_divider.sv */
`default_nettype none

module fmms_divider (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire fmms_pkg::div_stage_type div_in,
   output fmms_pkg::div_stage_type      div_out
);
   import fmms_pkg::*;

   div_stage_type stage_ff [DIV_STEPS+1];

   // restoring step: one quotient bit enters at the bottom of dq
   function automatic div_stage_type div_step(div_stage_type s);
      logic [VALUE_W:0]   shifted;
      logic [VALUE_W+1:0] diff;
      div_stage_type      n;
      n = s;
      shifted = {s.rem, s.dq[PROD_W-1]};
      diff = {1'b0, shifted} - {2'b00, s.den};
      if (!diff[VALUE_W+1]) begin
         n.rem = diff[VALUE_W-1:0];
         n.dq  = {s.dq[PROD_W-2:0], 1'b1};
      end else begin
         n.rem = shifted[VALUE_W-1:0];
         n.dq  = {s.dq[PROD_W-2:0], 1'b0};
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0] <= '0;
      end else if (advance) begin
         stage_ff[0] <= div_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k+1] <= '0;
         end else if (advance) begin
            stage_ff[k+1] <= div_step(stage_ff[k]);
         end
      end
   end

   assign div_out = stage_ff[DIV_STEPS];

endmodule

`default_nettype wire

/* sv/feature_min_max_scaler.sv */
// per-dimension min/max scaler for signed q16.16 feature elements. each request carries a
// kind (learn first, learn update, scale), a dimension index and a value; only scale
// requests produce a response, learn requests update the stored minimum and maximum of
// their dimension, and unused kinds or indexes at or above DIMENSIONS are dropped. one
// request is taken every cycle while the response side keeps up; a scale request passes
// through the min/max memory read, the multiplier and the 64-step pipelined divider to
// the response register. the stores are not cleared at reset: learn every dimension first
// before updating or scaling it. the user must write lower_bound and upper_bound through
// the csr port only while no request is in flight; the block does not enforce this.
`default_nettype none

module feature_min_max_scaler #(
   parameter int DIMENSIONS = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [fmms_pkg::INDEX_W-1:0]  req_dim_index,
   input  wire logic [fmms_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [fmms_pkg::INDEX_W-1:0]  rsp_out_index,
   output logic      [fmms_pkg::VALUE_W-1:0]  rsp_scaled_value,
   output logic                               rsp_flat_dimension,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [fmms_pkg::VALUE_W-1:0]  csr_write_data
);
   import fmms_pkg::*;

   localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int WW = AW + INDEX_W;

   // whole pipeline moves together; it stalls only while a response waits
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // configuration registers
   logic signed [VALUE_W-1:0] lower_bound_ff, upper_bound_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_bound_ff <= LOWER_BOUND_RESET;
         upper_bound_ff <= UPPER_BOUND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LOWER_BOUND: lower_bound_ff <= csr_write_data;
            CSR_UPPER_BOUND: upper_bound_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage 0: accept and issue the memory read
   logic [WW-1:0] idx_wide;
   logic          in_range, accept;
   assign idx_wide = WW'(req_dim_index);
   assign in_range = idx_wide < WW'(DIMENSIONS);
   assign accept   = req_valid && req_ready;

   logic                      s1_valid_ff;
   kind_type                  s1_kind_ff;
   logic [AW-1:0]             s1_addr_ff;
   logic [INDEX_W-1:0]        s1_idx_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && in_range && (kind_type'(req_kind) != KIND_UNUSED);
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= kind_type'(req_kind);
         s1_addr_ff  <= idx_wide[AW-1:0];
         s1_idx_ff   <= req_dim_index;
         s1_value_ff <= req_value;
      end
   end

   // stage 1: read data back, write the learned min/max
   logic signed [VALUE_W-1:0] mn, mx;
   logic                      wr_en;
   logic [VALUE_W-1:0]        wr_min, wr_max;

   fmms_store #(.DIMENSIONS(DIMENSIONS), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rd_addr (idx_wide[AW-1:0]),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_min  (wr_min),
      .wr_max  (wr_max),
      .rd_min  (mn),
      .rd_max  (mx)
   );

   always_comb begin
      wr_en  = 1'b0;
      wr_min = mn;
      wr_max = mx;
      case (s1_kind_ff)
         KIND_LEARN_FIRST: begin
            wr_en  = s1_valid_ff;
            wr_min = s1_value_ff;
            wr_max = s1_value_ff;
         end
         KIND_LEARN_UPDATE: begin
            wr_en = s1_valid_ff;
            if (s1_value_ff < mn) begin
               wr_min = s1_value_ff;
            end else if (s1_value_ff > mx) begin
               wr_max = s1_value_ff;
            end
         end
         default: ;
      endcase
   end

   // scale decision and operand magnitudes
   logic signed [VALUE_W:0] span, off, den;
   logic                    neg_raw, use_direct, flat;
   logic [VALUE_W-1:0]      direct;

   always_comb begin
      span = {upper_bound_ff[VALUE_W-1], upper_bound_ff}
             - {lower_bound_ff[VALUE_W-1], lower_bound_ff};
      off  = {s1_value_ff[VALUE_W-1], s1_value_ff} - {mn[VALUE_W-1], mn};
      den  = {mx[VALUE_W-1], mx} - {mn[VALUE_W-1], mn};
      neg_raw = (span[VALUE_W] ^ off[VALUE_W] ^ den[VALUE_W]) && (span != '0) && (off != '0);
      flat       = (mn == mx);
      use_direct = 1'b1;
      if (flat) begin
         direct = mn;
      end else if (s1_value_ff == mn) begin
         direct = lower_bound_ff;
      end else if (s1_value_ff == mx) begin
         direct = upper_bound_ff;
      end else begin
         direct     = mn;
         use_direct = 1'b0;
      end
   end

   function automatic logic [VALUE_W-1:0] mag33(logic [VALUE_W:0] x);
      logic [VALUE_W:0] m;
      m = x[VALUE_W] ? (~x + 1'b1) : x;
      return m[VALUE_W-1:0];
   endfunction

   // stage 2: operands to the multiplier
   div_stage_type      s2_ff;
   logic [VALUE_W-1:0] s2_span_ff, s2_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else if (advance) begin
         s2_ff.valid      <= s1_valid_ff && (s1_kind_ff == KIND_SCALE);
         s2_ff.idx        <= s1_idx_ff;
         s2_ff.flat       <= flat;
         s2_ff.use_direct <= use_direct;
         s2_ff.direct     <= direct;
         s2_ff.neg        <= neg_raw;
         s2_ff.den        <= mag33(den);
         s2_ff.rem        <= '0;
         s2_ff.dq         <= '0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_span_ff <= mag33(span);
         s2_off_ff  <= mag33(off);
      end
   end

   // product enters the divider as its dividend
   div_stage_type div_in, div_out;
   always_comb begin
      div_in    = s2_ff;
      div_in.dq = s2_span_ff * s2_off_ff;
   end

   fmms_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // final offset by lower_bound with saturation
   localparam int SW = QUOT_SAT_BIT + 3;
   localparam logic signed [SW-1:0] S32_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] S32_MIN = -SW'(64'sd2147483648);

   logic signed [SW-1:0] qs, sum;
   logic [VALUE_W-1:0]   result;
   logic                 q_big;

   always_comb begin
      q_big = div_out.dq > (PROD_W'(1) << QUOT_SAT_BIT);
      qs    = {2'b00, div_out.dq[QUOT_SAT_BIT:0]};
      sum   = SW'(lower_bound_ff) + (div_out.neg ? -qs : qs);
      if (div_out.use_direct) begin
         result = div_out.direct;
      end else if (q_big) begin
         result = div_out.neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (sum > S32_MAX) begin
         result = 32'h7fff_ffff;
      end else if (sum < S32_MIN) begin
         result = 32'h8000_0000;
      end else begin
         result = sum[VALUE_W-1:0];
      end
   end

   // response register
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_flat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_out.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_idx_ff   <= div_out.idx;
         rsp_value_ff <= result;
         rsp_flat_ff  <= div_out.flat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_index      = rsp_idx_ff;
   assign rsp_scaled_value   = rsp_value_ff;
   assign rsp_flat_dimension = rsp_flat_ff;

endmodule

`default_nettype wire

/* sv/fmms_checker.sv */
`default_nettype none

module fmms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [6:0]  rsp_out_index,
   input wire logic [31:0] rsp_scaled_value,
   input wire logic        rsp_flat_dimension
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
         && $stable(rsp_scaled_value) && $stable(rsp_flat_dimension))
      else $error("response changed while stalled");

   // request side only blocks behind a waiting response
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without a waiting response");

   // reset empties the output
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind feature_min_max_scaler fmms_checker u_fmms_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_index      (rsp_out_index),
   .rsp_scaled_value   (rsp_scaled_value),
   .rsp_flat_dimension (rsp_flat_dimension)
);

`default_nettype wire
